/* hdl/spfm_pkg.sv */
`timescale 1ns / 1ps

package spfm_pkg;

    // Command bytes on the link
    localparam logic [7:0] CMD_READ  = 8'h58;
    localparam logic [7:0] CMD_WRITE = 8'hA8;

    // Input function codes
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_RX    = 2'd2;

    // Received bytes ahead of the checksum byte
    localparam logic [1:0] RX_DATA_BYTES = 2'd3;

    localparam logic [2:0] MAX_TRIES_RESET = 3'd3;

    // Output kinds
    localparam logic KIND_TX     = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_REPORT
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  addr;
        logic [23:0] data;
        logic [7:0]  csum;
        logic        ok;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Inverted low byte of the sum of command, address and three data bytes
    function automatic logic [7:0] frame_sum(input logic [7:0] cmd,
                                             input logic [7:0] addr,
                                             input logic [23:0] data);
        logic [7:0] s;
        s = cmd + addr + data[23:16] + data[15:8] + data[7:0];
        return ~s;
    endfunction

endpackage

/* hdl/spfm_if.sv */
`timescale 1ns / 1ps

interface spfm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  reg_addr;
    logic [23:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, func, reg_addr, write_data, rx_byte, input ready);
    modport sink   (input valid, func, reg_addr, write_data, rx_byte, output ready);
endinterface

interface spfm_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  tx_byte;
    logic [23:0] read_data;
    logic        ok;
    logic        last;

    modport source (output valid, kind, tx_byte, read_data, ok, last, input ready);
    modport sink   (input valid, kind, tx_byte, read_data, ok, last, output ready);
endinterface

/* hdl/spfm_fifo.sv */
`timescale 1ns / 1ps

module spfm_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  spfm_pkg::t_job      i_wdata,
    input  logic                i_pop,
    output spfm_pkg::t_job      o_rdata,
    output spfm_pkg::t_fifo_stat o_stat
);

    spfm_pkg::t_job                r_mem [spfm_pkg::FIFO_DEPTH];
    logic [spfm_pkg::FIFO_AW-1:0]  r_wr_ptr;
    logic [spfm_pkg::FIFO_AW-1:0]  r_rd_ptr;
    logic [spfm_pkg::FIFO_AW:0]    r_count;

    // Status flags and head of queue
    assign o_stat.full  = (r_count == (spfm_pkg::FIFO_AW+1)'(spfm_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rdata      = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty job queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (spfm_pkg::FIFO_AW+1)'(spfm_pkg::FIFO_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

/* hdl/spfm_front.sv */
`timescale 1ns / 1ps

module spfm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_wdata,
    spfm_in_if.sink              i_in,
    input  spfm_pkg::t_fifo_stat i_stat,
    output logic                 o_push,
    output spfm_pkg::t_job       o_job
);

    logic [2:0]  r_tries_max;
    logic        r_pending;
    logic [7:0]  r_pend_addr;
    logic [1:0]  r_rx_count;
    logic [23:0] r_rx_shift;
    logic [2:0]  r_tries_used;

    logic        accept;
    logic        rx_match;
    logic        retry;

    // Take an item whenever the queue has room
    assign i_in.ready = !i_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    assign rx_match = (i_in.rx_byte ==
                       spfm_pkg::frame_sum(spfm_pkg::CMD_READ, r_pend_addr, r_rx_shift));
    assign retry    = (r_tries_used < r_tries_max);

    // Classify the item and build the job for the back end
    always_comb begin
        o_push    = 1'b0;
        o_job     = '0;
        o_job.kind = spfm_pkg::JOB_READ;
        case (i_in.func)
            spfm_pkg::FUNC_READ: begin
                o_push    = accept && !r_pending;
                o_job.kind = spfm_pkg::JOB_READ;
                o_job.addr = i_in.reg_addr;
            end
            spfm_pkg::FUNC_WRITE: begin
                o_push    = accept && !r_pending;
                o_job.kind = spfm_pkg::JOB_WRITE;
                o_job.addr = i_in.reg_addr;
                o_job.data = i_in.write_data;
                o_job.csum = spfm_pkg::frame_sum(spfm_pkg::CMD_WRITE, i_in.reg_addr,
                                                 i_in.write_data);
            end
            spfm_pkg::FUNC_RX: begin
                o_push = accept && r_pending && (r_rx_count == spfm_pkg::RX_DATA_BYTES);
                if (rx_match) begin
                    o_job.kind = spfm_pkg::JOB_REPORT;
                    o_job.data = r_rx_shift;
                    o_job.ok   = 1'b1;
                end else if (retry) begin
                    o_job.kind = spfm_pkg::JOB_READ;
                    o_job.addr = r_pend_addr;
                end else begin
                    o_job.kind = spfm_pkg::JOB_REPORT;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // Hold configuration and pending-read state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tries_max  <= spfm_pkg::MAX_TRIES_RESET;
            r_pending    <= 1'b0;
            r_pend_addr  <= '0;
            r_rx_count   <= '0;
            r_rx_shift   <= '0;
            r_tries_used <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tries_max <= i_cfg_wdata;
            end
            if (accept) begin
                case (i_in.func)
                    spfm_pkg::FUNC_READ: begin
                        if (!r_pending) begin
                            r_pending    <= 1'b1;
                            r_pend_addr  <= i_in.reg_addr;
                            r_tries_used <= 3'd1;
                            r_rx_count   <= '0;
                            r_rx_shift   <= '0;
                        end
                    end
                    spfm_pkg::FUNC_RX: begin
                        if (r_pending) begin
                            if (r_rx_count != spfm_pkg::RX_DATA_BYTES) begin
                                r_rx_shift <= {r_rx_shift[15:0], i_in.rx_byte};
                                r_rx_count <= r_rx_count + 1'b1;
                            end else if (rx_match || !retry) begin
                                r_pending  <= 1'b0;
                                r_rx_count <= '0;
                            end else begin
                                r_tries_used <= r_tries_used + 1'b1;
                                r_rx_count   <= '0;
                                r_rx_shift   <= '0;
                            end
                        end
                    end
                    default: begin
                        r_pending <= r_pending;
                    end
                endcase
            end
        end
    end

endmodule

/* hdl/spfm_back.sv */
`timescale 1ns / 1ps

module spfm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spfm_pkg::t_job       i_job,
    input  spfm_pkg::t_fifo_stat i_stat,
    output logic                 o_pop,
    spfm_out_if.source           o_out
);

    logic           r_busy;
    spfm_pkg::t_job r_job;
    logic [2:0]     r_step;
    logic           r_out_valid;
    logic           r_kind;
    logic [7:0]     r_tx_byte;
    logic [23:0]    r_read_data;
    logic           r_ok;
    logic           r_last;

    logic           load_out;
    logic           step_last;
    logic           n_kind;
    logic [7:0]     n_tx_byte;
    logic [23:0]    n_read_data;
    logic           n_ok;

    // Load the output register when it is empty or being drained
    assign load_out = r_busy && (!r_out_valid || o_out.ready);
    assign o_pop    = (!r_busy || (load_out && step_last)) && !i_stat.empty;

    // Pick the item for the current step of the job
    always_comb begin
        n_kind      = spfm_pkg::KIND_TX;
        n_tx_byte   = '0;
        n_read_data = '0;
        n_ok        = 1'b0;
        step_last   = 1'b0;
        case (r_job.kind)
            spfm_pkg::JOB_WRITE: begin
                step_last = (r_step == 3'd5);
                case (r_step)
                    3'd0:    n_tx_byte = spfm_pkg::CMD_WRITE;
                    3'd1:    n_tx_byte = r_job.addr;
                    3'd2:    n_tx_byte = r_job.data[23:16];
                    3'd3:    n_tx_byte = r_job.data[15:8];
                    3'd4:    n_tx_byte = r_job.data[7:0];
                    default: n_tx_byte = r_job.csum;
                endcase
            end
            spfm_pkg::JOB_READ: begin
                step_last = (r_step == 3'd1);
                n_tx_byte = (r_step == 3'd0) ? spfm_pkg::CMD_READ : r_job.addr;
            end
            spfm_pkg::JOB_REPORT: begin
                step_last   = 1'b1;
                n_kind      = spfm_pkg::KIND_REPORT;
                n_read_data = r_job.data;
                n_ok        = r_job.ok;
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
    end

    // Advance through jobs and hold the output item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (load_out && step_last) begin
                r_busy <= 1'b0;
            end else if (load_out) begin
                r_step <= r_step + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_kind      <= n_kind;
            r_tx_byte   <= n_tx_byte;
            r_read_data <= n_read_data;
            r_ok        <= n_ok;
            r_last      <= step_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.tx_byte   = r_tx_byte;
    assign o_out.read_data = r_read_data;
    assign o_out.ok        = r_ok;
    assign o_out.last      = r_last;

`ifndef SYNTHESIS
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == spfm_pkg::KIND_REPORT) |-> o_out.last)
        else $error("report item without last");

    a_tx_no_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == spfm_pkg::KIND_TX) |-> !o_out.ok)
        else $error("transmit item flagged ok");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || load_out))
        else $error("job popped while current job still running");
`endif

endmodule

/* hdl/spi_register_frame_master.sv */
`timescale 1ns / 1ps

// Register-link frame master for a metering chip.
// i_in carries requests and received bytes: with no read pending, func 0
// starts a read of reg_addr and func 1 writes write_data to reg_addr; func 2
// hands in one byte received from the chip. o_out carries bytes to transmit
// (kind 0) and read completion reports (kind 1); last marks the final item
// caused by an input. A write gives six bytes, a read request two, the
// fourth received byte of a read either a report or two bytes of a retried
// command. i_cfg_we / i_cfg_wdata set the read try limit (reset value 3).
// Items are taken one per cycle while the four-entry job queue has room; an
// accepted item passes the job queue, job register and output register before
// its first result shows on o_out. The output side gives one item per cycle
// while o_out is ready and jobs wait, so a write occupies it for six items, a
// read request for two, a report for one; the byte sequencer sets the sustained
// rate. When o_out is stalled its item holds, the queue fills, and i_in.ready
// drops once four jobs are waiting. Synchronous reset empties the queue and
// output register, clears any pending read and restores the try limit.

module spi_register_frame_master (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    spfm_in_if.sink     i_in,
    spfm_out_if.source  o_out
);

    logic                 push;
    logic                 pop;
    spfm_pkg::t_job       wjob;
    spfm_pkg::t_job       rjob;
    spfm_pkg::t_fifo_stat stat;

    spfm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_stat      (stat),
        .o_push      (push),
        .o_job       (wjob)
    );

    spfm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wjob),
        .i_pop   (pop),
        .o_rdata (rjob),
        .o_stat  (stat)
    );

    spfm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (rjob),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
